// ===== hdl/lse_pkg.sv =====
`timescale 1ns / 1ps

package lse_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  localparam logic [2:0] REQ_WRITE       = 3'd0;
  localparam logic [2:0] REQ_READ        = 3'd1;
  localparam logic [2:0] REQ_FILL        = 3'd2;
  localparam logic [2:0] REQ_FADE        = 3'd3;
  localparam logic [2:0] REQ_UNFADE      = 3'd4;
  localparam logic [2:0] REQ_FADE_TRAIL  = 3'd5;
  localparam logic [2:0] REQ_RANGE_FILL  = 3'd6;
  localparam logic [2:0] REQ_RANGE_TRAIL = 3'd7;

  localparam logic [7:0] CH_MAX            = 8'd255;
  localparam logic [7:0] WHEEL_THIRD       = 8'd85;
  localparam logic [7:0] WHEEL_TWO_THIRDS  = 8'd170;
  localparam logic [7:0] PIXEL_COUNT_RESET = 8'd128;

  // Color wheel: each third ramps one channel down and another one up, slope 3.
  function automatic rgb_t wheel_colour(input logic [7:0] p);
    logic [7:0] a;
    logic [7:0] m;
    rgb_t c;
    if (p < WHEEL_THIRD) begin
      a = p;
    end else if (p < WHEEL_TWO_THIRDS) begin
      a = p - WHEEL_THIRD;
    end else begin
      a = p - WHEEL_TWO_THIRDS;
    end
    m = {a[6:0], 1'b0} + a;
    if (p < WHEEL_THIRD) begin
      c.red = CH_MAX - m; c.green = '0; c.blue = m;
    end else if (p < WHEEL_TWO_THIRDS) begin
      c.red = '0; c.green = m; c.blue = CH_MAX - m;
    end else begin
      c.red = m; c.green = CH_MAX - m; c.blue = '0;
    end
    return c;
  endfunction

  // Send a position outside [s, e] back to s; the range may wrap.
  function automatic logic [7:0] bound_range(input logic [7:0] p, input logic [7:0] s,
                                             input logic [7:0] e);
    logic out_of_range;
    if (s <= e) begin
      out_of_range = (p > e) || (p < s);
    end else begin
      out_of_range = (p > e) && (p < s);
    end
    return out_of_range ? s : p;
  endfunction

  function automatic logic [7:0] sub_sat(input logic [7:0] v, input logic [15:0] d);
    return (d >= {8'd0, v}) ? 8'd0 : v - d[7:0];
  endfunction

  function automatic logic [7:0] add_sat(input logic [7:0] v, input logic [7:0] d);
    logic [8:0] t;
    t = {1'b0, v} + {1'b0, d};
    return (t >= {1'b0, CH_MAX}) ? CH_MAX : t[7:0];
  endfunction

endpackage

// ===== hdl/lse_ram.sv =====
`timescale 1ns / 1ps

module lse_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 128
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/lse_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module lse_div (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] dividend,
  input  logic [7:0] divisor,
  output logic       done,
  output logic [7:0] quotient,
  output logic [7:0] remainder
);

  localparam int W  = 8;
  localparam int CW = $clog2(W);

  logic          busy;
  logic [CW-1:0] steps;
  logic [W-1:0]  dvs;
  logic [W:0]    shifted;

  assign shifted = {remainder, quotient[W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && steps == CW'(W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
      steps     <= '0;
    end else if (busy) begin
      steps <= steps + 1'b1;
      if (shifted >= {1'b0, dvs}) begin
        remainder <= W'(shifted - {1'b0, dvs});
        quotient  <= {quotient[W-2:0], 1'b1};
      end else begin
        remainder <= shifted[W-1:0];
        quotient  <= {quotient[W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== hdl/led_strip_effect_engine_top.sv =====
`timescale 1ns / 1ps

// Sequence: every request divides index by count (S_DIV_POS); write and read then go
// to S_RDO and S_FIN, sweeps run S_RUN and S_DRAIN first, range trail also S_DIV_STEP.
// Throughput: one request at a time; the pixel sweep moves one pixel per cycle through the
// store's read and write ports, and each request runs one or two passes of the divider.
// Reset: pixels read as zero, wheel position 0, pixel_count 128; no clearing pass.
module led_strip_effect_engine_top #(
  parameter int MAX_PIXELS = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // index[6:0], red_in[14:7], green_in[22:15], blue_in[30:23], level[38:31],
  // wheel_start[46:39], wheel_end[54:47], ascending[55], restart[56], zero fill above
  input  logic [63:0] s_axis_tdata,
  // req_type[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // red_out[7:0], green_out[15:8], blue_out[23:16], wheel_now[31:24]
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  import lse_pkg::*;

  localparam int         AW      = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam logic [7:0] CNT_MAX = 8'(MAX_PIXELS);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DIV_POS  = 7'b0000010,
    S_DIV_STEP = 7'b0000100,
    S_RUN      = 7'b0001000,
    S_DRAIN    = 7'b0010000,
    S_RDO      = 7'b0100000,
    S_FIN      = 7'b1000000
  } state_t;

  state_t state;

  logic [7:0] pixel_count;
  logic [7:0] wheel_position;

  // latched request
  logic [2:0] req;
  rgb_t       rgb_in;
  logic [7:0] level;
  logic [7:0] wheel_start;
  logic [7:0] wheel_end;
  logic       ascending;
  logic [7:0] cnt;

  // sweep state
  logic [AW-1:0] pos;
  logic [AW-1:0] p;
  logic [7:0]    k;
  logic [15:0]   d;
  logic [7:0]    wp;
  logic [7:0]    step;

  // write-back stage
  logic          s1_valid;
  logic [AW-1:0] s1_addr;
  logic [15:0]   s1_d;
  logic [7:0]    s1_wp;

  logic [MAX_PIXELS-1:0] pix_valid;
  logic                  rd_valid;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  rgb_t          ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [23:0]   ram_rdata;

  logic       div_start;
  logic [7:0] div_dividend;
  logic [7:0] div_divisor;
  logic       div_done;
  logic [7:0] div_quo;
  logic [7:0] div_rem;

  logic       out_valid;
  rgb_t       out_rgb;
  logic [7:0] out_wheel;

  logic       in_accept;
  logic [7:0] cnt_eff;
  logic [7:0] fill_pos;
  logic [8:0] p_inc;
  logic [AW-1:0] p_next;
  rgb_t       old_px;
  rgb_t       new_px;
  logic       out_free;

  assign s_axis_tready = (state == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_wheel, out_rgb.blue, out_rgb.green, out_rgb.red};
  assign out_free      = !out_valid || m_axis_tready;

  always_comb begin
    if (pixel_count == 8'd0) begin
      cnt_eff = 8'd1;
    end else if (pixel_count > CNT_MAX) begin
      cnt_eff = CNT_MAX;
    end else begin
      cnt_eff = pixel_count;
    end
  end

  assign fill_pos = s_axis_tdata[56] ? s_axis_tdata[46:39] : wheel_position;

  // walk one pixel along the strip with wrap
  always_comb begin
    p_inc = 9'(p) + 9'd1;
    if (ascending) begin
      p_next = (p_inc >= {1'b0, cnt}) ? '0 : p_inc[AW-1:0];
    end else begin
      p_next = (p == '0) ? AW'(cnt - 8'd1) : p - 1'b1;
    end
  end

  // divider: index mod count first, then the trail step
  assign div_start    = in_accept ||
                        (state == S_DIV_POS && div_done && req == REQ_RANGE_TRAIL);
  assign div_dividend = (state == S_IDLE) ? {1'b0, s_axis_tdata[6:0]}
                                          : wheel_end - wheel_start;
  assign div_divisor  = (state == S_IDLE) ? cnt_eff : cnt;

  lse_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    old_px = rd_valid ? rgb_t'(ram_rdata) : '0;
    unique case (req)
      REQ_FADE, REQ_FADE_TRAIL: begin
        new_px.red   = sub_sat(old_px.red, s1_d);
        new_px.green = sub_sat(old_px.green, s1_d);
        new_px.blue  = sub_sat(old_px.blue, s1_d);
      end
      REQ_UNFADE: begin
        new_px.red   = add_sat(old_px.red, level);
        new_px.green = add_sat(old_px.green, level);
        new_px.blue  = add_sat(old_px.blue, level);
      end
      REQ_RANGE_FILL, REQ_RANGE_TRAIL: new_px = wheel_colour(s1_wp);
      default: new_px = rgb_in;
    endcase
  end

  always_comb begin
    if (state == S_DIV_POS && div_done && req == REQ_WRITE) begin
      ram_we    = 1'b1;
      ram_waddr = div_rem[AW-1:0];
      ram_wdata = rgb_in;
    end else begin
      ram_we    = s1_valid;
      ram_waddr = s1_addr;
      ram_wdata = new_px;
    end
    ram_raddr = (state == S_RUN) ? p : pos;
  end

  lse_ram #(
    .WIDTH (24),
    .DEPTH (MAX_PIXELS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // never-written pixels read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (ram_we) begin
        pix_valid[ram_waddr] <= 1'b1;
      end
      rd_valid <= pix_valid[ram_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      pixel_count    <= PIXEL_COUNT_RESET;
      wheel_position <= '0;
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        pixel_count <= cfg_data;
      end
      s1_valid <= (state == S_RUN);
      // load a new result or drop the one just taken
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (s_axis_tuser == REQ_RANGE_FILL) begin
              wheel_position <= bound_range(fill_pos + 8'd1, s_axis_tdata[46:39],
                                            s_axis_tdata[54:47]);
            end
            state <= S_DIV_POS;
          end
        end
        S_DIV_POS: begin
          if (div_done) begin
            priority if (req == REQ_WRITE || req == REQ_READ) begin
              state <= S_RDO;
            end else if (req == REQ_RANGE_TRAIL) begin
              state <= S_DIV_STEP;
            end else begin
              state <= S_RUN;
            end
          end
        end
        S_DIV_STEP: begin
          if (div_done) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (k == cnt - 8'd1) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: state <= S_RDO;
        S_RDO:   state <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    s1_addr <= p;
    s1_d    <= d;
    s1_wp   <= wp;

    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          req          <= s_axis_tuser;
          rgb_in.red   <= s_axis_tdata[14:7];
          rgb_in.green <= s_axis_tdata[22:15];
          rgb_in.blue  <= s_axis_tdata[30:23];
          level        <= s_axis_tdata[38:31];
          wheel_start  <= s_axis_tdata[46:39];
          wheel_end    <= s_axis_tdata[54:47];
          ascending    <= s_axis_tdata[55];
          cnt          <= cnt_eff;
          k            <= '0;
          step         <= '0;
          d            <= (s_axis_tuser == REQ_FADE_TRAIL) ? 16'd0
                                                           : {8'd0, s_axis_tdata[38:31]};
          wp           <= (s_axis_tuser == REQ_RANGE_FILL) ? fill_pos : s_axis_tdata[46:39];
        end
      end
      S_DIV_POS: begin
        if (div_done) begin
          pos <= div_rem[AW-1:0];
          p   <= div_rem[AW-1:0];
        end
      end
      S_DIV_STEP: begin
        if (div_done) begin
          step <= div_quo;
        end
      end
      S_RUN: begin
        k <= k + 8'd1;
        p <= p_next;
        if (req == REQ_FADE_TRAIL) begin
          d <= d + {8'd0, level};
        end
        if (req == REQ_RANGE_TRAIL) begin
          wp <= bound_range(wp + step, wheel_start, wheel_end);
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_rgb   <= rd_valid ? rgb_t'(ram_rdata) : '0;
          out_wheel <= wheel_position;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
